// File: rtl/core/bdd_pkg.sv
package bdd_pkg;

  // Defaults and fixed field widths
  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int LIMIT_W       = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 8;

  localparam logic               PRESS_LEVEL_RST = 1'b0;
  localparam logic [LIMIT_W-1:0] SETTLE_MS_RST   = 16'd20;
  localparam logic [LIMIT_W-1:0] HOLD_MS_RST     = 16'd1000;

  typedef enum logic [1:0] {
    PH_RELEASED        = 2'd0,
    PH_CONFIRM_PRESS   = 2'd1,
    PH_PRESSED         = 2'd2,
    PH_CONFIRM_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_CLICK   = 3'd3,
    EV_LONG    = 3'd4
  } evt_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_LEVEL = 2'd0,
    CFG_SETTLE_MS   = 2'd1,
    CFG_HOLD_MS     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic      press_seen;
    logic      release_seen;
    logic      click_seen;
    logic      long_seen;
    evt_code_t event_code;
  } bdd_evt_t;

endpackage

// File: rtl/core/bdd_core.sv
module bdd_core #(
  parameter int TIME_BITS = bdd_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         pin_level,
  input  logic [bdd_pkg::NOW_W-1:0]    now_ms,
  input  logic                         press_level,
  input  logic [bdd_pkg::LIMIT_W-1:0]  settle_ms,
  input  logic [bdd_pkg::LIMIT_W-1:0]  hold_ms,
  output bdd_pkg::bdd_evt_t            evt
);
  import bdd_pkg::*;

  phase_t               phase, phase_next;
  logic [TIME_BITS-1:0] edge_time, edge_time_next;
  logic [TIME_BITS-1:0] press_begin_time, press_begin_time_next;
  logic                 long_fired, long_fired_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] el_edge;
  logic [TIME_BITS-1:0] el_press;
  logic                 raw;
  logic                 deb_met;
  logic                 long_met;

  // Keep the low TIME_BITS of the time stamp, zero-extend if wider
  if (TIME_BITS <= NOW_W) begin : g_trunc
    assign now_t = now_ms[TIME_BITS-1:0];
  end else begin : g_ext
    assign now_t = {{(TIME_BITS - NOW_W){1'b0}}, now_ms};
  end

  assign raw      = (pin_level == press_level);
  assign el_edge  = now_t - edge_time;
  assign el_press = now_t - press_begin_time;
  assign deb_met  = (el_edge >= TIME_BITS'(settle_ms));
  assign long_met = (el_press >= TIME_BITS'(hold_ms));

  always_comb begin
    phase_next            = phase;
    edge_time_next        = edge_time;
    press_begin_time_next = press_begin_time;
    long_fired_next       = long_fired;
    evt.press_seen        = 1'b0;
    evt.release_seen      = 1'b0;
    evt.click_seen        = 1'b0;
    evt.long_seen         = 1'b0;

    unique case (phase)
      PH_RELEASED: begin
        if (raw) begin
          phase_next     = PH_CONFIRM_PRESS;
          edge_time_next = now_t;
        end
      end
      PH_CONFIRM_PRESS: begin
        if (!raw) begin
          phase_next = PH_RELEASED;
        end else if (deb_met) begin
          phase_next            = PH_PRESSED;
          press_begin_time_next = now_t;
          long_fired_next       = 1'b0;
          evt.press_seen        = 1'b1;
        end
      end
      PH_PRESSED: begin
        if (!raw) begin
          phase_next     = PH_CONFIRM_RELEASE;
          edge_time_next = now_t;
        end else if (!long_fired && long_met) begin
          long_fired_next = 1'b1;
          evt.long_seen   = 1'b1;
        end
      end
      PH_CONFIRM_RELEASE: begin
        if (raw) begin
          phase_next = PH_PRESSED;
        end else if (deb_met) begin
          phase_next       = PH_RELEASED;
          evt.release_seen = 1'b1;
          evt.click_seen   = !long_fired;
        end
      end
    endcase

    priority if (evt.press_seen)   evt.event_code = EV_PRESS;
    else if (evt.release_seen)     evt.event_code = EV_RELEASE;
    else if (evt.click_seen)       evt.event_code = EV_CLICK;
    else if (evt.long_seen)        evt.event_code = EV_LONG;
    else                           evt.event_code = EV_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RELEASED;
      edge_time        <= '0;
      press_begin_time <= '0;
      long_fired       <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      edge_time        <= edge_time_next;
      press_begin_time <= press_begin_time_next;
      long_fired       <= long_fired_next;
    end
  end

endmodule

// File: rtl/core/button_debounce_event_detector.sv
// Channel  Dir  Handshake            Payload
// -------  ---  -------------------  -----------------------------------------
// s_*      in   s_tvalid / s_tready  pin sample + ms time stamp (s_tdata)
// m_*      out  m_tvalid / m_tready  press/release/click/long flags + code
// cfg_*    in   cfg_we               register index + write data, no wait
//
// One item per clock while m_tready stays high; the result is offered after its item
// passes the input register, then the debounce state update into the result register.
// Reset clears the debounce machine to released, the time marks to zero and the
// registers to level 0, 20 ms debounce, 1000 ms long press.
// When m_tready is low the result register holds; one more item waits in the
// input register, and s_tready drops only when both are full.
module button_debounce_event_detector #(
  parameter int TIME_BITS = bdd_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bdd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic [bdd_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: [0] press_seen, [1] release_seen, [2] click_seen, [3] long_seen,
  //          [6:4] event_code, [7] zero
  output logic [bdd_pkg::M_TDATA_W-1:0]   m_tdata
);
  import bdd_pkg::*;

  // Configuration registers
  logic               press_level;
  logic [LIMIT_W-1:0] settle_ms;
  logic [LIMIT_W-1:0] hold_ms;

  // Input register
  logic             s1_valid;
  logic             s1_pin;
  logic [NOW_W-1:0] s1_now;
  logic             s1_adv;
  logic             s_accept;

  // Result register
  bdd_evt_t evt;
  bdd_evt_t m_evt;

  // Register writes; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      press_level <= PRESS_LEVEL_RST;
      settle_ms   <= SETTLE_MS_RST;
      hold_ms     <= HOLD_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESS_LEVEL: press_level <= cfg_data[0];
        CFG_SETTLE_MS:   settle_ms   <= cfg_data[LIMIT_W-1:0];
        CFG_HOLD_MS:     hold_ms     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the sample into the result register whenever that slot is free
  // or being emptied; the debounce state updates on the same edge.
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pin <= s_tdata[0];
      s1_now <= s_tdata[NOW_W:1];
    end
  end

  bdd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_adv),
    .pin_level   (s1_pin),
    .now_ms      (s1_now),
    .press_level (press_level),
    .settle_ms   (settle_ms),
    .hold_ms     (hold_ms),
    .evt         (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_evt <= evt;
    end
  end

  assign m_tdata = {1'b0, m_evt.event_code, m_evt.long_seen, m_evt.click_seen,
                    m_evt.release_seen, m_evt.press_seen};

  // A click only ever comes with its release
  a_click_with_release: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_evt.click_seen) |-> m_evt.release_seen)
    else $error("click without release");

  // The code follows the flags by priority
  a_code_press: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_evt.press_seen) |-> (m_evt.event_code == EV_PRESS))
    else $error("press flag without press code");

  // Long press fires only inside the pressed phase, never with an edge event
  a_long_alone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_evt.long_seen) |-> (!m_evt.press_seen && !m_evt.release_seen))
    else $error("long press together with press or release");

  // A waiting sample is not lost while the result side stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("input register dropped a waiting item");

endmodule

// File: tb/button_debounce_event_detector_tb.sv
module button_debounce_event_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 250;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  // s_tdata: [0] pin_level, [32:1] now_ms, [39:33] zero
  logic [S_TDATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // m_tdata: [0] press_seen, [1] release_seen, [2] click_seen, [3] long_seen,
  //          [6:4] event_code, [7] zero
  logic [M_TDATA_W-1:0]  m_tdata;

  button_debounce_event_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Predictor copy of the registers and of the debounce machine.
  logic               lvl_cfg    = PRESS_LEVEL_RST;
  logic [LIMIT_W-1:0] deb_cfg    = SETTLE_MS_RST;
  logic [LIMIT_W-1:0] long_cfg   = HOLD_MS_RST;
  phase_t             btn_phase  = PH_RELEASED;
  logic [NOW_W-1:0]   edge_mark  = '0;
  logic [NOW_W-1:0]   press_mark = '0;
  logic               long_done  = 1'b0;

  // Events predicted for accepted samples, oldest first.
  bdd_evt_t pending_events[$];

  int n_errors    = 0;
  int n_results   = 0;
  int cycle_count = 0;
  int s_idle_pct  = 0;
  int r_idle_pct  = 0;

  // Random button model: intended position plus a running ms clock.
  logic             btn_down = 1'b0;
  logic [NOW_W-1:0] sim_ms   = '0;

  // Directed plan: register writes and samples, optionally with a hand-typed event.
  typedef struct {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  pin;
    logic [NOW_W-1:0]      stamp;
    logic                  known;
    bdd_evt_t              want;
  } plan_row_t;

  plan_row_t stim_plan[$];

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    stim_plan.push_back(row);
  endfunction

  // flags: {long, click, release, press}
  function automatic void add_item(input logic pin, input logic [NOW_W-1:0] stamp,
                                   input logic known, input logic [3:0] flags,
                                   input evt_code_t code);
    plan_row_t row;
    row                   = '{default: '0};
    row.pin               = pin;
    row.stamp             = stamp;
    row.known             = known;
    row.want.press_seen   = flags[0];
    row.want.release_seen = flags[1];
    row.want.click_seen   = flags[2];
    row.want.long_seen    = flags[3];
    row.want.event_code   = code;
    stim_plan.push_back(row);
  endfunction

  // Advance the debounce machine by one sample and give the events it raises.
  task automatic predict_event(input logic pin, input logic [NOW_W-1:0] stamp,
                               output bdd_evt_t ev);
    logic             hit;
    logic [NOW_W-1:0] since_edge;
    logic [NOW_W-1:0] since_press;
    hit         = (pin == lvl_cfg);
    // Wrapping differences: a clock rollover between marks is harmless.
    since_edge  = stamp - edge_mark;
    since_press = stamp - press_mark;
    ev          = '0;
    case (btn_phase)
      PH_RELEASED: begin
        if (hit) begin
          btn_phase = PH_CONFIRM_PRESS;
          edge_mark = stamp;
        end
      end
      PH_CONFIRM_PRESS: begin
        // Bounce drops back to released; a steady level becomes a press.
        if (!hit) begin
          btn_phase = PH_RELEASED;
        end else if (since_edge >= deb_cfg) begin
          btn_phase     = PH_PRESSED;
          press_mark    = stamp;
          long_done     = 1'b0;
          ev.press_seen = 1'b1;
        end
      end
      PH_PRESSED: begin
        if (!hit) begin
          btn_phase = PH_CONFIRM_RELEASE;
          edge_mark = stamp;
        end else if (!long_done && since_press >= long_cfg) begin
          long_done    = 1'b1;
          ev.long_seen = 1'b1;
        end
      end
      default: begin
        // Coming back pressed keeps the press mark and the long-fired bit.
        if (hit) begin
          btn_phase = PH_PRESSED;
        end else if (since_edge >= deb_cfg) begin
          btn_phase       = PH_RELEASED;
          ev.release_seen = 1'b1;
          ev.click_seen   = !long_done;
        end
      end
    endcase
    if (ev.press_seen)        ev.event_code = EV_PRESS;
    else if (ev.release_seen) ev.event_code = EV_RELEASE;
    else if (ev.click_seen)   ev.event_code = EV_CLICK;
    else if (ev.long_seen)    ev.event_code = EV_LONG;
    else                      ev.event_code = EV_NONE;
  endtask

  // Offer one sample, idling at random first; return at the edge that takes it.
  // s_tvalid stays high on return so back-to-back items need no re-raise.
  task automatic push_sample(input logic pin, input logic [NOW_W-1:0] stamp,
                             input logic known, input bdd_evt_t want);
    bdd_evt_t guess;
    while ($urandom_range(99) < s_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - NOW_W - 1){1'b0}}, stamp, pin};
    do @(posedge clk); while (!s_tready);
    predict_event(pin, stamp, guess);
    // Hand-typed rows stand on their own; the predictor still tracks the state.
    pending_events.push_back(known ? want : guess);
  endtask

  // Drop valid and hold until every predicted event has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  // Write one register with the block idle; the extra edge keeps cfg_we
  // from being lowered and raised in one step on back-to-back writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PRESS_LEVEL: lvl_cfg  = val[0];
      CFG_SETTLE_MS:   deb_cfg  = val;
      CFG_HOLD_MS:     long_cfg = val;
      default: ;
    endcase
  endtask

  // Mostly a button held or released for a while, with occasional bounce,
  // time steps scaled to the current limits and rare jumps near the wrap.
  task automatic next_random_sample(output logic pin, output logic [NOW_W-1:0] stamp);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2)       sim_ms = $urandom;
    else if (roll < 4)  sim_ms = 32'hFFFF_FFFF - $urandom_range(deb_cfg + 40);
    else if (roll < 40) sim_ms = sim_ms + $urandom_range(3);
    else if (roll < 85) sim_ms = sim_ms + $urandom_range(deb_cfg + 2);
    else                sim_ms = sim_ms + $urandom_range(long_cfg / 2 + 2);
    if ($urandom_range(99) < 6) btn_down = !btn_down;
    pin = btn_down ? lvl_cfg : !lvl_cfg;
    if ($urandom_range(99) < 6) pin = !pin;
    stamp = sim_ms;
  endtask

  task automatic check_result(input logic [M_TDATA_W-1:0] word);
    bdd_evt_t want;
    n_results++;
    if (pending_events.size() == 0) begin
      $error("result %h arrived with no item waiting", word);
      n_errors++;
      return;
    end
    want = pending_events.pop_front();
    if (word[0] !== want.press_seen) begin
      $error("press_seen: expected %0d, got %0d", want.press_seen, word[0]);
      n_errors++;
    end
    if (word[1] !== want.release_seen) begin
      $error("release_seen: expected %0d, got %0d", want.release_seen, word[1]);
      n_errors++;
    end
    if (word[2] !== want.click_seen) begin
      $error("click_seen: expected %0d, got %0d", want.click_seen, word[2]);
      n_errors++;
    end
    if (word[3] !== want.long_seen) begin
      $error("long_seen: expected %0d, got %0d", want.long_seen, word[3]);
      n_errors++;
    end
    if (word[6:4] !== want.event_code) begin
      $error("event_code: expected %0d, got %0d", want.event_code, word[6:4]);
      n_errors++;
    end
  endtask

  // Result side: check every accepted item, stall at random, and once hold
  // off long enough for the block to fill and drop s_tready.
  initial begin : result_sink
    int   hold_left;
    logic held_once;
    hold_left = 0;
    held_once = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) check_result(m_tdata);
      if (!held_once && n_results == 400) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= r_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic             pin;
    logic [NOW_W-1:0] stamp;
    int               sent;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed plan. Registers start at reset: level 0 means pressed,
    // 20 ms debounce, 1000 ms long press.
    add_item(1'b1, 32'd0,    1'b1, 4'b0000, EV_NONE);
    add_item(1'b0, 32'd5,    1'b1, 4'b0000, EV_NONE);
    add_item(1'b1, 32'd10,   1'b1, 4'b0000, EV_NONE);    // press bounces away
    add_item(1'b0, 32'd100,  1'b1, 4'b0000, EV_NONE);
    add_item(1'b0, 32'd119,  1'b1, 4'b0000, EV_NONE);    // one ms short
    add_item(1'b0, 32'd120,  1'b1, 4'b0001, EV_PRESS);
    add_item(1'b1, 32'd130,  1'b1, 4'b0000, EV_NONE);
    add_item(1'b0, 32'd140,  1'b1, 4'b0000, EV_NONE);    // release bounces back
    add_item(1'b0, 32'd1119, 1'b1, 4'b0000, EV_NONE);
    add_item(1'b0, 32'd1120, 1'b1, 4'b1000, EV_LONG);
    add_item(1'b1, 32'd3000, 1'b1, 4'b0000, EV_NONE);
    add_item(1'b1, 32'd3020, 1'b1, 4'b0010, EV_RELEASE); // no click after long
    add_item(1'b0, 32'hFFFF_FFF0, 1'b1, 4'b0000, EV_NONE);
    add_item(1'b0, 32'd4,    1'b1, 4'b0001, EV_PRESS);   // debounce across the wrap
    add_item(1'b1, 32'd10,   1'b1, 4'b0000, EV_NONE);
    add_item(1'b1, 32'd30,   1'b1, 4'b0110, EV_RELEASE); // release with click
    // Bits above the level bit are dropped; zero limits fire on the next sample.
    add_cfg(CFG_PRESS_LEVEL, 16'hFFFF);
    add_cfg(CFG_SETTLE_MS, 16'd0);
    add_cfg(CFG_HOLD_MS, 16'd0);
    add_cfg(CFG_UNUSED_IDX, 16'h1234);
    add_item(1'b1, 32'h8000_0000, 1'b1, 4'b0000, EV_NONE);
    add_item(1'b1, 32'h8000_0000, 1'b1, 4'b0001, EV_PRESS);
    add_item(1'b1, 32'h8000_0000, 1'b1, 4'b1000, EV_LONG);
    add_item(1'b0, 32'h8000_0000, 1'b1, 4'b0000, EV_NONE);
    add_item(1'b0, 32'h8000_0000, 1'b1, 4'b0010, EV_RELEASE);
    // Largest limits; left to the predictor.
    add_cfg(CFG_PRESS_LEVEL, 16'hFFFE);
    add_cfg(CFG_SETTLE_MS, 16'hFFFF);
    add_cfg(CFG_HOLD_MS, 16'hFFFF);
    add_item(1'b0, 32'd0,     1'b0, 4'b0000, EV_NONE);
    add_item(1'b0, 32'd65534, 1'b0, 4'b0000, EV_NONE);
    add_item(1'b0, 32'd65535, 1'b0, 4'b0000, EV_NONE);

    s_idle_pct = 13;
    r_idle_pct = 54;
    foreach (stim_plan[k]) begin
      if (stim_plan[k].is_cfg)
        write_reg(stim_plan[k].idx, stim_plan[k].val);
      else
        push_sample(stim_plan[k].pin, stim_plan[k].stamp, stim_plan[k].known,
                    stim_plan[k].want);
    end

    // Random part: one register setting per phase, the extremes among them.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_PRESS_LEVEL, 16'd0);
          write_reg(CFG_SETTLE_MS, 16'd20);
          write_reg(CFG_HOLD_MS, 16'd1000);
        end
        1: begin
          write_reg(CFG_PRESS_LEVEL, 16'd1);
          write_reg(CFG_SETTLE_MS, 16'd0);
          write_reg(CFG_HOLD_MS, 16'd0);
        end
        2: begin
          write_reg(CFG_PRESS_LEVEL, 16'd0);
          write_reg(CFG_SETTLE_MS, 16'hFFFF);
          write_reg(CFG_HOLD_MS, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_PRESS_LEVEL, 16'd1);
          write_reg(CFG_SETTLE_MS, CFG_DATA_W'($urandom_range(40)));
          write_reg(CFG_HOLD_MS, CFG_DATA_W'($urandom_range(400)));
        end
        4, 5: begin
          write_reg(CFG_PRESS_LEVEL, CFG_DATA_W'($urandom));
          write_reg(CFG_SETTLE_MS, CFG_DATA_W'($urandom));
          write_reg(CFG_HOLD_MS, CFG_DATA_W'($urandom));
        end
        default: begin
          write_reg(CFG_PRESS_LEVEL, 16'd0);
          write_reg(CFG_SETTLE_MS, 16'd5);
          write_reg(CFG_HOLD_MS, 16'd30);
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sent = p * PHASE_ITEMS + n;
        // Swap the idle rates after a third, then run flat out.
        if (sent == 583) begin
          s_idle_pct = 54;
          r_idle_pct = 13;
        end
        if (sent == 1166) begin
          s_idle_pct = 0;
          r_idle_pct = 0;
        end
        // Pause mid-phase until the pipe is empty, then carry on.
        if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
        next_random_sample(pin, stamp);
        push_sample(pin, stamp, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: button_debounce_event_detector.f
rtl/core/bdd_pkg.sv
rtl/core/bdd_core.sv
rtl/core/button_debounce_event_detector.sv
tb/button_debounce_event_detector_tb.sv
